FILE: rtl/gcoin_pkg.sv
// Shared types and constants for the greedy coin change block.
// No dependencies; every other file refers to it by scoped names.
package gcoin_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int COIN_WIDTH  = 16;
    localparam int REG_COUNT   = 8;
    localparam int DENOM_W     = 16;
    localparam int AMOUNT_W    = 32;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DIV_CNT_W   = $clog2(AMOUNT_W);

    localparam logic [DENOM_W-1:0] COIN_MASK = (COIN_WIDTH >= DENOM_W)
        ? {DENOM_W{1'b1}}
        : DENOM_W'((64'd1 << COIN_WIDTH) - 64'd1);

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_NOFIT = 2'd1;
    localparam status_t ST_DUP   = 2'd2;
    localparam status_t ST_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        KIND_WORK,
        KIND_DUP,
        KIND_EMPTY
    } kind_t;

    typedef logic [DENOM_W-1:0] denom_t;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [AMOUNT_W-1:0]    amount;
        kind_t                  kind;
        denom_t [NUM_SLOTS-1:0] sorted;
    } job_t;

endpackage

FILE: rtl/gcoin_front.sv
// Front end: configuration registers, request intake, sorting and classification.
// Depends on gcoin_pkg; feeds gcoin_queue.
module gcoin_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [gcoin_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gcoin_pkg::DENOM_W-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [gcoin_pkg::AMOUNT_W-1:0]    amount,
    output logic                              push,
    output gcoin_pkg::job_t                   push_job,
    input  logic                              queue_full
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_SORT,
        F_PUSH
    } fstate_t;

    localparam logic [gcoin_pkg::SLOT_W-1:0] LAST_SLOT =
        gcoin_pkg::SLOT_W'(gcoin_pkg::NUM_SLOTS - 1);

    fstate_t                                    state_reg;
    gcoin_pkg::denom_t [gcoin_pkg::REG_COUNT-1:0] denom_reg;
    gcoin_pkg::denom_t [gcoin_pkg::NUM_SLOTS-1:0] sorted_reg;
    gcoin_pkg::denom_t [gcoin_pkg::NUM_SLOTS-1:0] sorted_next;
    logic [gcoin_pkg::AMOUNT_W-1:0]             amount_reg;
    logic [gcoin_pkg::SLOT_W-1:0]               slot_reg;
    logic                                       dup_reg;
    gcoin_pkg::denom_t                          cur_v;
    logic [gcoin_pkg::NUM_SLOTS-1:0]            keep;
    logic                                       hit;

    assign cur_v = denom_reg[slot_reg] & gcoin_pkg::COIN_MASK;

    // Insertion into the descending list: entries not below the new value stay,
    // the first smaller one takes it, and the rest move down one place.
    always_comb
    begin
        hit = 1'b0;
        for (int j = 0; j < gcoin_pkg::NUM_SLOTS; j++)
        begin
            keep[j] = (sorted_reg[j] >= cur_v);
            hit     = hit | (sorted_reg[j] == cur_v);
        end
        sorted_next[0] = keep[0] ? sorted_reg[0] : cur_v;
        for (int j = 1; j < gcoin_pkg::NUM_SLOTS; j++)
        begin
            if (keep[j])
            begin
                sorted_next[j] = sorted_reg[j];
            end
            else if (keep[j-1])
            begin
                sorted_next[j] = cur_v;
            end
            else
            begin
                sorted_next[j] = sorted_reg[j-1];
            end
        end
    end

    assign in_stall = (state_reg != F_IDLE);
    assign push     = (state_reg == F_PUSH) && !queue_full;

    always_comb
    begin
        push_job.amount = amount_reg;
        push_job.sorted = sorted_reg;
        if (dup_reg)
        begin
            push_job.kind = gcoin_pkg::KIND_DUP;
        end
        else if (amount_reg == '0)
        begin
            push_job.kind = gcoin_pkg::KIND_EMPTY;
        end
        else
        begin
            push_job.kind = gcoin_pkg::KIND_WORK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            denom_reg <= '0;
        end
        else if (cfg_write)
        begin
            denom_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            sorted_reg <= '0;
            amount_reg <= '0;
            slot_reg   <= '0;
            dup_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        amount_reg <= amount;
                        sorted_reg <= '0;
                        slot_reg   <= '0;
                        dup_reg    <= 1'b0;
                        state_reg  <= F_SORT;
                    end
                end
                F_SORT:
                begin
                    if (cur_v != '0)
                    begin
                        sorted_reg <= sorted_next;
                        if (hit)
                        begin
                            dup_reg <= 1'b1;
                        end
                    end
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_reg <= F_PUSH;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                F_PUSH:
                begin
                    if (!queue_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/gcoin_queue.sv
// Short queue of classified requests between the front and the back.
// Depends on gcoin_pkg for the entry type and depth.
module gcoin_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gcoin_pkg::job_t push_job,
    input  logic            pop,
    output gcoin_pkg::job_t pop_job,
    output logic            full,
    output logic            empty
);

    localparam logic [gcoin_pkg::QPTR_W-1:0] LAST_PTR =
        gcoin_pkg::QPTR_W'(gcoin_pkg::QUEUE_DEPTH - 1);

    gcoin_pkg::job_t                entry_reg [gcoin_pkg::QUEUE_DEPTH];
    logic [gcoin_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [gcoin_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [gcoin_pkg::QPTR_W:0]     count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == (gcoin_pkg::QPTR_W + 1)'(gcoin_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // The front only offers an entry when there is room for it.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

endmodule

FILE: rtl/gcoin_divider.sv
// Restoring divider, one quotient bit per cycle: amount by one denomination.
// Depends on gcoin_pkg for widths.
module gcoin_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [gcoin_pkg::AMOUNT_W-1:0] dividend,
    input  gcoin_pkg::denom_t              divisor,
    output logic                           busy,
    output logic                           done,
    output logic [gcoin_pkg::AMOUNT_W-1:0] quotient,
    output gcoin_pkg::denom_t              remainder
);

    logic [gcoin_pkg::AMOUNT_W-1:0]  quo_reg;
    gcoin_pkg::denom_t               rem_reg;
    gcoin_pkg::denom_t               div_reg;
    logic [gcoin_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [gcoin_pkg::DENOM_W:0]     trial;
    logic [gcoin_pkg::DENOM_W:0]     diff;

    // The partial remainder stays below the divisor, so one extra bit is enough.
    assign trial = {rem_reg, quo_reg[gcoin_pkg::AMOUNT_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
                cnt_reg  <= gcoin_pkg::DIV_CNT_W'(gcoin_pkg::AMOUNT_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!diff[gcoin_pkg::DENOM_W])
                begin
                    rem_reg <= diff[gcoin_pkg::DENOM_W-1:0];
                    quo_reg <= {quo_reg[gcoin_pkg::AMOUNT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[gcoin_pkg::DENOM_W-1:0];
                    quo_reg <= {quo_reg[gcoin_pkg::AMOUNT_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/gcoin_back.sv
// Back end: greedy pass over the sorted denominations and run-length output.
// Depends on gcoin_pkg and gcoin_divider; drains gcoin_queue.
module gcoin_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  gcoin_pkg::job_t                q_job,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [gcoin_pkg::DENOM_W-1:0]  coin_value,
    output logic [gcoin_pkg::COUNT_W-1:0]  coin_count,
    output logic [1:0]                     status,
    output logic                           last
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_ISSUE,
        B_WAIT,
        B_CHECK,
        B_SCAN,
        B_OUT
    } bstate_t;

    localparam logic [gcoin_pkg::SLOT_W-1:0] LAST_SLOT =
        gcoin_pkg::SLOT_W'(gcoin_pkg::NUM_SLOTS - 1);

    bstate_t                                      state_reg;
    gcoin_pkg::denom_t [gcoin_pkg::NUM_SLOTS-1:0] sorted_reg;
    logic [gcoin_pkg::AMOUNT_W-1:0]               rem_reg;
    logic [gcoin_pkg::SLOT_W-1:0]                 idx_reg;
    logic [gcoin_pkg::SLOT_W-1:0]                 lastk_reg;
    logic [gcoin_pkg::COUNT_W-1:0]                counts_reg [gcoin_pkg::NUM_SLOTS];
    logic                                         out_valid_reg;
    gcoin_pkg::denom_t                            coin_value_reg;
    logic [gcoin_pkg::COUNT_W-1:0]                coin_count_reg;
    gcoin_pkg::status_t                           status_reg;
    logic                                         last_reg;

    gcoin_pkg::denom_t                            cur_d;
    logic [gcoin_pkg::COUNT_W-1:0]                cur_count;
    logic                                         div_start;
    logic                                         div_busy;
    logic                                         div_done;
    logic [gcoin_pkg::AMOUNT_W-1:0]               div_quo;
    gcoin_pkg::denom_t                            div_rem;

    assign cur_d     = sorted_reg[idx_reg];
    assign cur_count = counts_reg[idx_reg];
    assign div_start = (state_reg == B_ISSUE) && (cur_d != '0);
    assign pop       = (state_reg == B_IDLE) && !q_empty;

    assign out_valid  = out_valid_reg;
    assign coin_value = coin_value_reg;
    assign coin_count = coin_count_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    gcoin_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rem_reg),
        .divisor   (cur_d),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Per-slot coin counts; every slot is written before the output scan reads it.
    always_ff @(posedge clk)
    begin
        if ((state_reg == B_ISSUE) && (cur_d == '0))
        begin
            counts_reg[idx_reg] <= '0;
        end
        else if ((state_reg == B_WAIT) && div_done)
        begin
            counts_reg[idx_reg] <= div_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            sorted_reg     <= '0;
            rem_reg        <= '0;
            idx_reg        <= '0;
            lastk_reg      <= '0;
            out_valid_reg  <= 1'b0;
            coin_value_reg <= '0;
            coin_count_reg <= '0;
            status_reg     <= gcoin_pkg::ST_OK;
            last_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        sorted_reg     <= q_job.sorted;
                        coin_value_reg <= '0;
                        coin_count_reg <= '0;
                        last_reg       <= 1'b1;
                        unique case (q_job.kind)
                            gcoin_pkg::KIND_DUP:
                            begin
                                status_reg    <= gcoin_pkg::ST_DUP;
                                out_valid_reg <= 1'b1;
                                state_reg     <= B_OUT;
                            end
                            gcoin_pkg::KIND_EMPTY:
                            begin
                                rem_reg       <= '0;
                                status_reg    <= gcoin_pkg::ST_EMPTY;
                                out_valid_reg <= 1'b1;
                                state_reg     <= B_OUT;
                            end
                            default:
                            begin
                                rem_reg   <= q_job.amount;
                                idx_reg   <= '0;
                                state_reg <= B_ISSUE;
                            end
                        endcase
                    end
                end
                B_ISSUE:
                begin
                    if (cur_d != '0)
                    begin
                        state_reg <= B_WAIT;
                    end
                    else if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= B_CHECK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                B_WAIT:
                begin
                    if (div_done)
                    begin
                        rem_reg <= {{(gcoin_pkg::AMOUNT_W - gcoin_pkg::DENOM_W){1'b0}},
                                    div_rem};
                        if (div_quo != '0)
                        begin
                            lastk_reg <= idx_reg;
                        end
                        if (idx_reg == LAST_SLOT)
                        begin
                            state_reg <= B_CHECK;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= B_ISSUE;
                        end
                    end
                end
                B_CHECK:
                begin
                    if (rem_reg != '0)
                    begin
                        coin_value_reg <= '0;
                        coin_count_reg <= '0;
                        status_reg     <= gcoin_pkg::ST_NOFIT;
                        last_reg       <= 1'b1;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= B_OUT;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= B_SCAN;
                    end
                end
                B_SCAN:
                begin
                    if (cur_count != '0)
                    begin
                        coin_value_reg <= cur_d;
                        coin_count_reg <= cur_count;
                        status_reg     <= gcoin_pkg::ST_OK;
                        last_reg       <= (idx_reg == lastk_reg);
                        out_valid_reg  <= 1'b1;
                        state_reg      <= B_OUT;
                    end
                    else if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                B_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg || (idx_reg == LAST_SLOT))
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= B_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_fail_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != gcoin_pkg::ST_OK))
            |-> (last_reg && (coin_value_reg == '0) && (coin_count_reg == '0)))
        else $error("failure result must be a lone final result with zero fields");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == gcoin_pkg::ST_OK))
            |-> ((coin_count_reg != '0) && (coin_value_reg != '0)))
        else $error("run result with zero value or count");

    a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WAIT) |-> (div_busy || div_done))
        else $error("waiting on a divider that is not running");

    a_out_only_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == B_OUT))
        else $error("result offered outside the output state");

endmodule

FILE: rtl/greedy_coin_change_core.sv
// Top level of the greedy coin change block.
// Depends on gcoin_pkg, gcoin_front, gcoin_queue and gcoin_back.
//
// Usage:
//   Denominations are written through cfg_write/cfg_index/cfg_data while the
//   block is idle; slot value 0 leaves a slot unused.
//   An amount is a transfer on the input channel (in_valid high, in_stall low).
//   The front copies it, sorts the used denominations by insertion, one slot
//   per cycle, flags duplicates and an empty amount, and queues the request;
//   the queue holds two requests.
//   The back divides the remainder by each used denomination in turn with a
//   shared one-bit-per-cycle divider, then scans the slots, emitting a result
//   per nonzero count and passing over the zero-count slots.
//   Results leave as run-length pairs, largest coin first, with last on the
//   final one; a duplicate set, an empty amount or a remainder that does not
//   fit yields a single result with that status.
//   The output register holds a result while out_stall is high; the back
//   waits, while the front and queue keep taking new amounts until full.
//   Reset clears the denominations to zero and empties the queue.
module greedy_coin_change_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [gcoin_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gcoin_pkg::DENOM_W-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [gcoin_pkg::AMOUNT_W-1:0]    amount,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gcoin_pkg::DENOM_W-1:0]     coin_value,
    output logic [gcoin_pkg::COUNT_W-1:0]     coin_count,
    output logic [1:0]                        status,
    output logic                              last
);

    logic            push;
    gcoin_pkg::job_t push_job;
    logic            queue_full;
    logic            pop;
    gcoin_pkg::job_t pop_job;
    logic            queue_empty;

    gcoin_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .amount     (amount),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    gcoin_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    gcoin_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (queue_empty),
        .q_job      (pop_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .coin_value (coin_value),
        .coin_count (coin_count),
        .status     (status),
        .last       (last)
    );

endmodule

FILE: tb/greedy_coin_change_core_tb.sv
// Self-checking testbench for greedy_coin_change_core: directed table, then random phases.
// Depends on gcoin_pkg and the RTL of the block; expected coin runs come from a local predictor.
module greedy_coin_change_core_tb;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 400;
    localparam int HOLD_CYCLES   = 3000;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 45;
    localparam int DIRECTED_ROWS = 23;
    localparam int NUM_SETS      = 6;

    typedef struct packed {
        gcoin_pkg::denom_t             value;
        logic [gcoin_pkg::COUNT_W-1:0] count;
        gcoin_pkg::status_t            code;
        logic                          is_last;
    } coin_run_t;

    typedef struct {
        int                             set_id;
        logic [gcoin_pkg::AMOUNT_W-1:0] amt;
        bit                             typed;
        gcoin_pkg::status_t             code;
    } change_row_t;

    typedef enum int {
        MIX_SMALL,
        MIX_WIDE,
        MIX_DUP,
        MIX_EXTREME
    } denom_mix_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_write = 1'b0;
    logic [gcoin_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [gcoin_pkg::DENOM_W-1:0]     cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [gcoin_pkg::AMOUNT_W-1:0]    amount = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [gcoin_pkg::DENOM_W-1:0]     coin_value;
    logic [gcoin_pkg::COUNT_W-1:0]     coin_count;
    logic [1:0]                        status;
    logic                              last;

    greedy_coin_change_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .amount     (amount),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .coin_value (coin_value),
        .coin_count (coin_count),
        .status     (status),
        .last       (last)
    );

    // Testbench copy of the denomination registers and the runs still to arrive.
    gcoin_pkg::denom_t denom_reg [gcoin_pkg::REG_COUNT] = '{default: '0};
    gcoin_pkg::denom_t next_set [gcoin_pkg::REG_COUNT];
    coin_run_t         coin_runs_due [$];
    int                errors = 0;
    int                send_idle_pct = 23;
    int                recv_idle_pct = 75;
    bit                hold_req = 1'b0;

    gcoin_pkg::denom_t denom_sets [NUM_SETS][gcoin_pkg::REG_COUNT] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd25, 16'd1, 16'd100, 16'd0, 16'd10, 16'd50, 16'd5, 16'd0},
        '{16'd7, 16'd3, 16'd0, 16'd12, 16'd7, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'hFFFF, 16'h8000, 16'hFFFE, 16'd2, 16'h0101, 16'h7FFF, 16'd3},
        '{16'd6, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF}
    };

    change_row_t directed_rows [DIRECTED_ROWS] = '{
        '{0, 32'd0,          1'b1, gcoin_pkg::ST_EMPTY},
        '{0, 32'd1,          1'b1, gcoin_pkg::ST_NOFIT},
        '{0, 32'hFFFF_FFFF,  1'b1, gcoin_pkg::ST_NOFIT},
        '{1, 32'd0,          1'b1, gcoin_pkg::ST_EMPTY},
        '{1, 32'd1,          1'b0, gcoin_pkg::ST_OK},
        '{1, 32'd4,          1'b0, gcoin_pkg::ST_OK},
        '{1, 32'd41,         1'b0, gcoin_pkg::ST_OK},
        '{1, 32'd289,        1'b0, gcoin_pkg::ST_OK},
        '{1, 32'hFFFF_FFFF,  1'b0, gcoin_pkg::ST_OK},
        '{2, 32'd0,          1'b1, gcoin_pkg::ST_DUP},
        '{2, 32'd14,         1'b1, gcoin_pkg::ST_DUP},
        '{2, 32'hFFFF_FFFF,  1'b1, gcoin_pkg::ST_DUP},
        '{3, 32'hFFFF_FFFF,  1'b0, gcoin_pkg::ST_OK},
        '{3, 32'h0000_FFFF,  1'b0, gcoin_pkg::ST_OK},
        '{3, 32'h8000_0000,  1'b0, gcoin_pkg::ST_OK},
        '{3, 32'd1,          1'b0, gcoin_pkg::ST_OK},
        '{4, 32'd8,          1'b0, gcoin_pkg::ST_OK},
        '{4, 32'd10,         1'b0, gcoin_pkg::ST_OK},
        '{4, 32'd3,          1'b1, gcoin_pkg::ST_NOFIT},
        '{4, 32'd0,          1'b1, gcoin_pkg::ST_EMPTY},
        '{5, 32'hFFFF_FFFF,  1'b0, gcoin_pkg::ST_OK},
        '{5, 32'd65535,      1'b0, gcoin_pkg::ST_OK},
        '{5, 32'd65534,      1'b1, gcoin_pkg::ST_NOFIT}
    };

    always #CLK_HALF clk = ~clk;

    function automatic void push_single(input gcoin_pkg::status_t code);
        coin_run_t run;
        run.value   = '0;
        run.count   = '0;
        run.code    = code;
        run.is_last = 1'b1;
        coin_runs_due.push_back(run);
    endfunction

    // Greedy split of one amount over the current denominations, largest first.
    function automatic void split_amount(input logic [gcoin_pkg::AMOUNT_W-1:0] amt);
        gcoin_pkg::denom_t              ladder [gcoin_pkg::REG_COUNT];
        logic [gcoin_pkg::COUNT_W-1:0]  counts [gcoin_pkg::REG_COUNT];
        logic [gcoin_pkg::AMOUNT_W-1:0] rest;
        gcoin_pkg::denom_t              v;
        int                             used;
        int                             j;
        int                             final_slot;
        coin_run_t                      run;
        used = 0;
        for (int i = 0; i < gcoin_pkg::REG_COUNT; i++) ladder[i] = '0;
        for (int i = 0; i < gcoin_pkg::NUM_SLOTS && i < gcoin_pkg::REG_COUNT; i++) begin
            v = denom_reg[i] & gcoin_pkg::COIN_MASK;
            if (v != '0) begin
                j = used;
                while (j > 0 && ladder[j-1] < v) begin
                    ladder[j] = ladder[j-1];
                    j--;
                end
                ladder[j] = v;
                used++;
            end
        end
        // The duplicate check wins over every other outcome, even amount zero.
        for (int i = 0; i + 1 < used; i++) begin
            if (ladder[i] == ladder[i+1]) begin
                push_single(gcoin_pkg::ST_DUP);
                return;
            end
        end
        if (amt == '0) begin
            push_single(gcoin_pkg::ST_EMPTY);
            return;
        end
        rest = amt;
        for (int i = 0; i < used; i++) begin
            counts[i] = rest / 32'(ladder[i]);
            rest      = rest % 32'(ladder[i]);
        end
        if (rest != '0) begin
            push_single(gcoin_pkg::ST_NOFIT);
            return;
        end
        final_slot = -1;
        for (int i = 0; i < used; i++)
            if (counts[i] != '0) final_slot = i;
        for (int i = 0; i < used; i++) begin
            if (counts[i] != '0) begin
                run.value   = ladder[i];
                run.count   = counts[i];
                run.code    = gcoin_pkg::ST_OK;
                run.is_last = (i == final_slot);
                coin_runs_due.push_back(run);
            end
        end
    endfunction

    function automatic logic [gcoin_pkg::AMOUNT_W-1:0] pick_amount();
        logic [gcoin_pkg::AMOUNT_W-1:0] sum;
        int                             r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 8) return '1;
        if (r < 40) return gcoin_pkg::AMOUNT_W'($urandom_range(5000));
        if (r < 70) return $urandom;
        // Built from the coins themselves, so a combination exists even without a unit coin; greedy may still miss it.
        sum = '0;
        for (int i = 0; i < gcoin_pkg::REG_COUNT; i++)
            sum += gcoin_pkg::AMOUNT_W'($urandom_range(3))
                   * gcoin_pkg::AMOUNT_W'(denom_reg[i]);
        return sum;
    endfunction

    function automatic void make_distinct();
        bit clash;
        for (int i = 1; i < gcoin_pkg::REG_COUNT; i++) begin
            if (next_set[i] != '0) begin
                do begin
                    clash = 1'b0;
                    for (int j = 0; j < i; j++)
                        if (next_set[j] == next_set[i]) clash = 1'b1;
                    if (clash) next_set[i] = gcoin_pkg::DENOM_W'($urandom_range(2, 65535));
                end while (clash);
            end
        end
    endfunction

    function automatic void random_denominations(input denom_mix_t mix);
        int one_slot;
        int dup_slot;
        one_slot = $urandom_range(gcoin_pkg::REG_COUNT - 1);
        for (int i = 0; i < gcoin_pkg::REG_COUNT; i++) begin
            if ($urandom_range(99) < 20)
                next_set[i] = '0;
            else if (mix == MIX_WIDE || mix == MIX_EXTREME)
                next_set[i] = gcoin_pkg::DENOM_W'($urandom_range(1, 65535));
            else
                next_set[i] = gcoin_pkg::DENOM_W'($urandom_range(2, 400));
        end
        if (mix == MIX_EXTREME) begin
            next_set[one_slot] = 16'd1;
            next_set[(one_slot + 3) % gcoin_pkg::REG_COUNT] = 16'hFFFF;
        end else if (mix != MIX_WIDE || $urandom_range(1) == 1) begin
            next_set[one_slot] = 16'd1;
        end
        make_distinct();
        if (mix == MIX_DUP) begin
            dup_slot = (one_slot + $urandom_range(1, gcoin_pkg::REG_COUNT - 1))
                       % gcoin_pkg::REG_COUNT;
            next_set[dup_slot] = next_set[one_slot];
        end
    endfunction

    task automatic write_denominations();
        for (int i = 0; i < gcoin_pkg::REG_COUNT; i++) begin
            cfg_write <= 1'b1;
            cfg_index <= gcoin_pkg::CFG_INDEX_W'(i);
            cfg_data  <= next_set[i];
            @(posedge clk);
            denom_reg[i] = next_set[i];
        end
        cfg_write <= 1'b0;
    endtask

    // Stop offering amounts and wait until every expected run has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (coin_runs_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offers one amount and returns at the edge where the transfer happens;
    // valid stays high so the next amount can follow without a gap.
    task automatic send_amount(input logic [gcoin_pkg::AMOUNT_W-1:0] amt, input bit typed,
                               input gcoin_pkg::status_t code);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        amount   <= amt;
        do @(posedge clk); while (in_stall);
        if (typed) push_single(code);
        else split_amount(amt);
    endtask

    initial begin : stimulus
        int         cur_set;
        denom_mix_t mix;
        cur_set = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].set_id != cur_set) begin
                drain_results();
                cur_set = directed_rows[r].set_id;
                for (int i = 0; i < gcoin_pkg::REG_COUNT; i++)
                    next_set[i] = denom_sets[cur_set][i];
                write_denominations();
            end
            send_amount(directed_rows[r].amt, directed_rows[r].typed, directed_rows[r].code);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 23;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            unique case (p)
                2, 7:    mix = MIX_EXTREME;
                3, 8:    mix = MIX_WIDE;
                5:       mix = MIX_DUP;
                default: mix = MIX_SMALL;
            endcase
            drain_results();
            random_denominations(mix);
            write_denominations();
            // Output held off for a long stretch while amounts keep coming in.
            if (p == 1) hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 4 && k == PHASE_ITEMS / 2) drain_results();
                send_amount(pick_amount(), 1'b0, gcoin_pkg::ST_OK);
            end
        end

        in_valid <= 1'b0;
        while (coin_runs_due.size() != 0) @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (errors == 0 && coin_runs_due.size() == 0)
            $display("greedy_coin_change_core test passed");
        else
            $display("greedy_coin_change_core test failed");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin : check_result
        coin_run_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (coin_runs_due.size() == 0) begin
                $error("result transfer with nothing expected: value %0d count %0d status %0d",
                       coin_value, coin_count, status);
                errors++;
            end else begin
                want = coin_runs_due.pop_front();
                if (coin_value !== want.value) begin
                    $error("coin_value: expected %0d, got %0d", want.value, coin_value);
                    errors++;
                end
                if (coin_count !== want.count) begin
                    $error("coin_count: expected %0d, got %0d", want.count, coin_count);
                    errors++;
                end
                if (status !== want.code) begin
                    $error("status: expected %0d, got %0d", want.code, status);
                    errors++;
                end
                if (last !== want.is_last) begin
                    $error("last: expected %0d, got %0d", want.is_last, last);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        #12_000_000;
        $display("greedy_coin_change_core test failed");
        $finish;
    end

endmodule
